@@ rtl/core/ptsb_pkg.sv @@
// Shared types and codes of the periodic timer slot bank.
package ptsb_pkg;

    // Request kinds carried on the input tuser
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    // Result kinds carried on the output tuser
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_FIRE   = 2'd2;
    localparam logic [1:0] KIND_TICK   = 2'd3;

    // Add outcomes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam int IN_DATA_W  = 200;
    localparam int OUT_DATA_W = 200;
    localparam int DIV_STEPS  = 32;

    // One slot entry as kept in the slot memory
    typedef struct packed {
        logic [31:0] handler;
        logic [31:0] period;
        logic [31:0] deadline;
        logic [31:0] arg_a;
        logic [31:0] arg_b;
        logic [31:0] arg_c;
        logic [31:0] arg_d;
    } slot_rec_t;

    // One result transaction before the tick count is attached
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [31:0] handler;
        logic [31:0] arg_a;
        logic [31:0] arg_b;
        logic [31:0] arg_c;
        logic [31:0] arg_d;
        logic        last;
    } result_t;

endpackage

@@ rtl/core/periodic_timer_slot_bank_unit.sv @@
// Top level of the periodic timer slot bank: slot memory, divider and sequencer.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tuser req_type, tdata request fields
//  m_axis    out  m_axis_tvalid/tready      tuser kind, tdata result fields, tlast
//  cfg       in   cfg_wr_en                 cfg_wr_data tick_interval
//
// Remove: straight to output. Add: runs the one-bit-per-cycle restoring
// divider for the rounded-up period, unless rejected or full. Tick: a slot
// memory read and compare per slot, plus one output per fire.
// Reset clears the tick count, all slot valid bits and the output valid flag.
// A stalled output holds the sequencer; one waiting result does not block
// the acceptance of the next request.
module periodic_timer_slot_bank_unit #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: handler[31:0], delay[63:32], arg_a[95:64], arg_b[127:96],
    //        arg_c[159:128], arg_d[191:160], target_slot[195:192], zero[199:196]
    input  logic [ptsb_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: status[1:0], slot[5:2], fired_handler[37:6], out_arg_a[69:38],
    //        out_arg_b[101:70], out_arg_c[133:102], out_arg_d[165:134],
    //        now_ticks[197:166], zero[199:198]
    output logic [ptsb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: kind[1:0]
    output logic [1:0]                     m_axis_tuser,
    output logic                           m_axis_tlast,
    input  logic                           cfg_wr_en,
    input  logic [15:0]                    cfg_wr_data
);
    import ptsb_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    // Registers
    logic [2:0]           state_reg, state_next;
    logic [15:0]          interval_reg;
    logic [31:0]          tick_reg, tick_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [15:0]          div_reg, div_next;
    logic [31:0]          quot_reg, quot_next;
    logic [15:0]          rem_reg, rem_next;
    logic [4:0]           step_reg, step_next;
    slot_rec_t            req_reg, req_next;
    result_t              res_reg, res_next;
    result_t              out_reg, out_next;
    logic [31:0]          out_now_reg, out_now_next;
    logic                 out_valid_reg, out_valid_next;

    // Slot memory
    slot_rec_t            slot_mem [NUM_SLOTS];
    slot_rec_t            rd_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    slot_rec_t            wr_data;

    logic                 in_acc;
    logic                 out_free;
    logic                 any_free;
    logic [IDX_W-1:0]     free_idx;
    logic [16:0]          trial;
    logic                 trial_ge;
    logic [31:0]          new_deadline;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // Find the lowest free slot
    always_comb
    begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                any_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // One restoring division step
    assign trial    = {rem_reg, quot_reg[31]};
    assign trial_ge = (trial >= {1'b0, div_reg});
    assign new_deadline = tick_reg + rd_data.period;

    // Sequencer
    always_comb
    begin
        result_t r;
        r            = '0;
        state_next   = state_reg;
        tick_next    = tick_reg;
        valid_next   = valid_reg;
        idx_next     = idx_reg;
        div_next     = div_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        req_next     = req_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        out_now_next = out_now_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    r.last = 1'b1;
                    case (s_axis_tuser)
                        REQ_ADD:
                        begin
                            r.kind = KIND_ADD;
                            req_next.handler = s_axis_tdata[31:0];
                            req_next.period  = s_axis_tdata[63:32];
                            req_next.arg_a   = s_axis_tdata[95:64];
                            req_next.arg_b   = s_axis_tdata[127:96];
                            req_next.arg_c   = s_axis_tdata[159:128];
                            req_next.arg_d   = s_axis_tdata[191:160];
                            if (s_axis_tdata[31:0] == '0 || s_axis_tdata[63:32] == '0)
                            begin
                                r.status   = ST_REJECT;
                                res_next   = r;
                                state_next = S_EMIT;
                            end
                            else if (!any_free)
                            begin
                                r.status   = ST_FULL;
                                res_next   = r;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                idx_next   = free_idx;
                                div_next   = (interval_reg == '0) ? 16'd1 : interval_reg;
                                quot_next  = s_axis_tdata[63:32];
                                rem_next   = '0;
                                step_next  = '0;
                                state_next = S_DIV;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (32'(s_axis_tdata[195:192]) < 32'(NUM_SLOTS))
                            begin
                                valid_next[IDX_W'(s_axis_tdata[195:192])] = 1'b0;
                            end
                            r.kind     = KIND_REMOVE;
                            r.slot     = s_axis_tdata[195:192];
                            res_next   = r;
                            state_next = S_EMIT;
                        end
                        REQ_TICK:
                        begin
                            tick_next  = tick_reg + 32'd1;
                            idx_next   = '0;
                            state_next = S_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                rem_next  = trial_ge ? 16'(trial - {1'b0, div_reg}) : trial[15:0];
                quot_next = {quot_reg[30:0], trial_ge};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(DIV_STEPS - 1))
                begin
                    // Round up and store the new slot
                    wr_data.handler  = req_reg.handler;
                    wr_data.period   = {quot_reg[30:0], trial_ge}
                                       + 32'(rem_next != '0);
                    wr_data.deadline = tick_reg + wr_data.period;
                    wr_data.arg_a    = req_reg.arg_a;
                    wr_data.arg_b    = req_reg.arg_b;
                    wr_data.arg_c    = req_reg.arg_c;
                    wr_data.arg_d    = req_reg.arg_d;
                    wr_en            = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    r.kind     = KIND_ADD;
                    r.slot     = 4'(idx_reg);
                    r.last     = 1'b1;
                    res_next   = r;
                    state_next = S_EMIT;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (valid_reg[idx_reg] && rd_data.deadline <= tick_reg)
                begin
                    wr_data.deadline = new_deadline;
                    wr_en      = 1'b1;
                    r.kind     = KIND_FIRE;
                    r.slot     = 4'(idx_reg);
                    r.handler  = rd_data.handler;
                    r.arg_a    = rd_data.arg_a;
                    r.arg_b    = rd_data.arg_b;
                    r.arg_c    = rd_data.arg_c;
                    r.arg_d    = rd_data.arg_d;
                    res_next   = r;
                    state_next = S_EMIT;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    r.kind     = KIND_TICK;
                    r.last     = 1'b1;
                    res_next   = r;
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_now_next   = tick_reg;
                    out_valid_next = 1'b1;
                    if (res_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        r.kind   = KIND_TICK;
                        r.last   = 1'b1;
                        res_next = r;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data <= slot_mem[idx_reg];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            interval_reg  <= 16'd1;
            tick_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                interval_reg <= cfg_wr_data;
            end
        end
    end

    // Payload and datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        div_reg     <= div_next;
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
        req_reg     <= req_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
        out_now_reg <= out_now_next;
    end

    // Output transaction
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {2'b00, out_now_reg, out_reg.arg_d, out_reg.arg_c,
                            out_reg.arg_b, out_reg.arg_a, out_reg.handler,
                            out_reg.slot, out_reg.status};

    // A fire transaction is never the last of its request
    a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_FIRE |-> !m_axis_tlast)
        else $error("fire result marked last");

    // The tick count moves only on an accepted tick request
    a_tick_source: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(tick_reg) |-> $past(in_acc && s_axis_tuser == REQ_TICK))
        else $error("tick count changed without a tick request");

    // The divider always runs with a nonzero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_reg != '0)
        else $error("division by zero in period computation");

endmodule
